@@ hdl/lphj_pkg.sv @@
// shared types, constants and codes of the hash join table unit
`timescale 1ns / 1ps

package lphj_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_MATCHES = 63;
    localparam int ROW_BITS    = 32;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int STEP_BITS   = IDX_BITS;
    localparam int CNT_BITS    = $clog2(MAX_MATCHES + 1);
    localparam int EPOCH_BITS  = 8;
    localparam int MIN_BITS    = 4;

    localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_PROBE  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_MATCH = 2'd2,
        STAT_END   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_INNER = 2'd0,
        MODE_SEMI  = 2'd1,
        MODE_ANTI  = 2'd2,
        MODE_ALT   = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        REG_TABLE_BITS = 1'b0,
        REG_JOIN_MODE  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_HASH0,
        ST_HASH1,
        ST_HASH2,
        ST_READ,
        ST_CHECK,
        ST_FIN
    } state_t;

    // one table slot: epoch tag marks it valid, then key and row
    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [31:0]           key;
        logic [ROW_BITS-1:0]   row;
    } slot_t;

    // memory access bundle from the walk control
    typedef struct packed {
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_addr;
        slot_t               wr_data;
    } mem_req_t;

endpackage

@@ hdl/lphj_if.sv @@
// valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface lphj_in_if;
    import lphj_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic [31:0]        row;

    modport source (output valid, operation, key, row, input ready);
    modport sink (input valid, operation, key, row, output ready);
endinterface

interface lphj_out_if;
    import lphj_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] build_row;
    logic [31:0] probe_row;
    logic        selected;
    logic        truncated;
    logic        last;

    modport source (output valid, status, build_row, probe_row, selected, truncated, last,
                    input ready);
    modport sink (input valid, status, build_row, probe_row, selected, truncated, last,
                  output ready);
endinterface

@@ hdl/lphj_table.sv @@
// slot memory of the hash table, one read and one write port, registered read
`timescale 1ns / 1ps

module lphj_table
    import lphj_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output slot_t    rd_data
);

    slot_t mem [TABLE_DEPTH];
    slot_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/linear_probe_hash_join_table_unit.sv @@
// top level of the linear-probing hash join table unit
//
//  channel   dir   protocol      payload
//  items     in    valid/ready   operation, key, row
//  results   out   valid/ready   status, build_row, probe_row, selected, truncated, last
//  config    in    apb           table_bits (0x0), join_mode (0x4)
//
// one item at a time: insert and probe run the transfer, then the hashing states HASH0, HASH1, HASH2,
// then a memory read and a compare per visited slot, then the end result
// clear bumps the epoch; every 255th clear runs a sweep of all 4096 slots of the slot memory
// after reset the same sweep runs before the first item is taken
// a stalled result output holds the walk in place; the next item waits for the end result
`timescale 1ns / 1ps

module linear_probe_hash_join_table_unit
    import lphj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lphj_in_if.sink     items,
    lphj_out_if.source  results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [31:0]           key_reg, key_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic [31:0]           h_reg, h_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  found_reg, found_next;
    logic                  trunc_reg, trunc_next;
    status_t               fin_reg, fin_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [IDX_BITS-1:0]   sweep_reg, sweep_next;
    logic                  sweep_fin_reg, sweep_fin_next;
    logic [3:0]            tbits_reg;
    mode_t                 mode_reg;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [31:0]           out_brow_reg, out_brow_next;
    logic [31:0]           out_prow_reg, out_prow_next;
    logic                  out_sel_reg, out_sel_next;
    logic                  out_trunc_reg, out_trunc_next;
    logic                  out_last_reg, out_last_next;

    mem_req_t              req;
    slot_t                 rd;
    logic [3:0]            tb_eff;
    logic [IDX_BITS-1:0]   mask;
    logic                  out_free;
    logic                  inner;
    logic                  hit;
    logic                  kmatch;
    logic                  last_slot;
    logic [31:0]           mix_in;
    logic [63:0]           prod;
    logic [31:0]           h_fold;

    lphj_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd)
    );

    // apb config registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbits_reg <= 4'd12;
            mode_reg  <= MODE_INNER;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_TABLE_BITS: tbits_reg <= pwdata[3:0];
                REG_JOIN_MODE:  mode_reg  <= mode_t'(pwdata[1:0]);
                default:        tbits_reg <= tbits_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_TABLE_BITS: prdata = {28'd0, tbits_reg};
            REG_JOIN_MODE:  prdata = {30'd0, mode_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // slots in use: clamp the bit count, then build the index mask
    always_comb
    begin
        if (tbits_reg < 4'(MIN_BITS))
        begin
            tb_eff = 4'(MIN_BITS);
        end
        else if (tbits_reg > 4'(IDX_BITS))
        begin
            tb_eff = 4'(IDX_BITS);
        end
        else
        begin
            tb_eff = tbits_reg;
        end
        mask = IDX_BITS'(((IDX_BITS+1)'(1) << tb_eff) - (IDX_BITS+1)'(1));
    end

    // walk compare terms
    assign inner     = (mode_reg != MODE_SEMI) && (mode_reg != MODE_ANTI);
    assign hit       = (rd.epoch == epoch_reg);
    assign kmatch    = hit && (rd.key == key_reg);
    assign last_slot = (step_reg == STEP_BITS'(mask));
    assign out_free  = !out_valid_reg || results.ready;

    // murmur3 finalizer, one multiply per cycle
    always_comb
    begin
        if (state_reg == ST_HASH0)
        begin
            mix_in = key_reg ^ (key_reg >> 16);
            prod   = mix_in * MIX_C1;
        end
        else
        begin
            mix_in = h_reg ^ (h_reg >> 13);
            prod   = mix_in * MIX_C2;
        end
        h_fold = h_reg ^ (h_reg >> 16);
    end

    assign items.ready = (state_reg == ST_IDLE);

    // control and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        row_next        = row_reg;
        h_next          = h_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        trunc_next      = trunc_reg;
        fin_next        = fin_reg;
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        sweep_fin_next  = sweep_fin_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_status_next = out_status_reg;
        out_brow_next   = out_brow_reg;
        out_prow_next   = out_prow_reg;
        out_sel_next    = out_sel_reg;
        out_trunc_next  = out_trunc_reg;
        out_last_next   = out_last_reg;
        req.rd_en       = 1'b0;
        req.rd_addr     = idx_reg;
        req.wr_en       = 1'b0;
        req.wr_addr     = idx_reg;
        req.wr_data     = '{epoch: epoch_reg, key: key_reg, row: row_reg};

        case (state_reg)
            ST_SWEEP:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = sweep_reg;
                req.wr_data = '0;
                sweep_next  = sweep_reg + IDX_BITS'(1);
                if (sweep_reg == IDX_BITS'(TABLE_DEPTH - 1))
                begin
                    state_next     = sweep_fin_reg ? ST_FIN : ST_IDLE;
                    sweep_fin_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (items.valid)
                begin
                    op_next    = op_t'(items.operation);
                    key_next   = items.key;
                    row_next   = items.row[ROW_BITS-1:0];
                    step_next  = '0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    trunc_next = 1'b0;
                    fin_next   = STAT_DONE;
                    case (op_t'(items.operation))
                        OP_CLEAR:
                        begin
                            // new epoch invalidates every slot; wrap needs a sweep
                            if (epoch_reg == {EPOCH_BITS{1'b1}})
                            begin
                                epoch_next     = EPOCH_BITS'(1);
                                sweep_next     = '0;
                                sweep_fin_next = 1'b1;
                                state_next     = ST_SWEEP;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + EPOCH_BITS'(1);
                                state_next = ST_FIN;
                            end
                        end
                        OP_INSERT, OP_PROBE: state_next = ST_HASH0;
                        default:             state_next = ST_FIN;
                    endcase
                end
            end
            ST_HASH0:
            begin
                h_next     = prod[31:0];
                state_next = ST_HASH1;
            end
            ST_HASH1:
            begin
                h_next     = prod[31:0];
                state_next = ST_HASH2;
            end
            ST_HASH2:
            begin
                idx_next   = h_fold[IDX_BITS-1:0] & mask;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                req.rd_en  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (!hit)
                    begin
                        req.wr_en  = 1'b1;
                        fin_next   = STAT_DONE;
                        state_next = ST_FIN;
                    end
                    else if (last_slot)
                    begin
                        fin_next   = STAT_FULL;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        idx_next   = (idx_reg + IDX_BITS'(1)) & mask;
                        step_next  = step_reg + STEP_BITS'(1);
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    fin_next = STAT_END;
                    if (!hit)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (kmatch && !inner)
                    begin
                        found_next = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (kmatch && (cnt_reg < CNT_BITS'(MAX_MATCHES)))
                    begin
                        // report the pair; hold the walk while the output is busy
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_MATCH;
                            out_brow_next   = 32'(rd.row);
                            out_prow_next   = 32'(row_reg);
                            out_sel_next    = 1'b0;
                            out_trunc_next  = 1'b0;
                            out_last_next   = 1'b0;
                            cnt_next        = cnt_reg + CNT_BITS'(1);
                            found_next      = 1'b1;
                            if (last_slot)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                idx_next   = (idx_reg + IDX_BITS'(1)) & mask;
                                step_next  = step_reg + STEP_BITS'(1);
                                state_next = ST_READ;
                            end
                        end
                    end
                    else
                    begin
                        if (kmatch)
                        begin
                            found_next = 1'b1;
                            trunc_next = 1'b1;
                        end
                        if (last_slot)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            idx_next   = (idx_reg + IDX_BITS'(1)) & mask;
                            step_next  = step_reg + STEP_BITS'(1);
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_FIN:
            begin
                // final result of the item
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_reg;
                    out_brow_next   = 32'd0;
                    out_last_next   = 1'b1;
                    if (op_reg == OP_PROBE)
                    begin
                        out_prow_next  = 32'(row_reg);
                        out_sel_next   = (mode_reg == MODE_ANTI) ? !found_reg : found_reg;
                        out_trunc_next = trunc_reg;
                    end
                    else
                    begin
                        out_prow_next  = 32'd0;
                        out_sel_next   = 1'b0;
                        out_trunc_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            epoch_reg     <= EPOCH_BITS'(1);
            sweep_reg     <= '0;
            sweep_fin_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            sweep_fin_reg <= sweep_fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        row_reg        <= row_next;
        h_reg          <= h_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        trunc_reg      <= trunc_next;
        fin_reg        <= fin_next;
        out_status_reg <= out_status_next;
        out_brow_reg   <= out_brow_next;
        out_prow_reg   <= out_prow_next;
        out_sel_reg    <= out_sel_next;
        out_trunc_reg  <= out_trunc_next;
        out_last_reg   <= out_last_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.status    = out_status_reg;
    assign results.build_row = out_brow_reg;
    assign results.probe_row = out_prow_reg;
    assign results.selected  = out_sel_reg;
    assign results.truncated = out_trunc_reg;
    assign results.last      = out_last_reg;

`ifndef SYNTHESIS
    // an item transfer leaves the idle state, so the next item waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> !items.ready)
        else $error("item accepted while busy");

    // a match pair is never the final result
    a_match_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == STAT_MATCH) |-> !out_last_reg)
        else $error("match result marked last");

    // memory writes only from the insert check or the sweep
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (state_reg == ST_SWEEP) ||
                      ((state_reg == ST_CHECK) && (op_reg == OP_INSERT)))
        else $error("unexpected table write");

    // epoch zero is reserved for swept slots
    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch reached the swept value");
`endif

endmodule

@@ tb/tb_linear_probe_hash_join_table_unit.sv @@
// self-checking testbench of the linear-probing hash join table unit
`timescale 1ns / 1ps

module tb_linear_probe_hash_join_table_unit;
    import lphj_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT        = 150;

    typedef struct {
        op_t         op;
        logic [31:0] key;
        logic [31:0] row;
        bit          drain;
    } join_item_t;

    typedef struct {
        status_t     status;
        logic [31:0] build_row;
        logic [31:0] probe_row;
        logic        selected;
        logic        truncated;
        logic        last;
    } join_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lphj_in_if  items ();
    lphj_out_if results ();

    linear_probe_hash_join_table_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the table and registers
    logic [31:0] shadow_key [TABLE_DEPTH];
    logic [31:0] shadow_row [TABLE_DEPTH];
    bit          shadow_used [TABLE_DEPTH];
    logic [3:0]  cur_table_bits;
    mode_t       cur_mode;

    join_item_t   pending_q[$];
    join_result_t expected_q[$];
    logic [31:0]  key_pool[8];

    int  errors;
    int  items_added;
    int  items_sent;
    int  results_seen;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_done;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] mix_key(input logic [31:0] k);
        logic [31:0] h;
        h = k;
        h = h ^ (h >> 16);
        h = h * MIX_C1;
        h = h ^ (h >> 13);
        h = h * MIX_C2;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // expected results of one accepted item
    function automatic void predict_join(input join_item_t it);
        int          tb_bits;
        int          n;
        logic [31:0] mask;
        logic [31:0] idx;
        int          step;
        int          k;
        bit          found;
        bit          trunc;
        bit          inner;
        join_result_t r;
        tb_bits = cur_table_bits;
        if (tb_bits < MIN_BITS)
            tb_bits = MIN_BITS;
        n = 1 << tb_bits;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        mask = n - 1;
        idx = mix_key(it.key) & mask;
        r = '{STAT_DONE, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1};
        case (it.op)
            OP_CLEAR:
            begin
                foreach (shadow_used[i])
                    shadow_used[i] = 1'b0;
            end
            OP_INSERT:
            begin
                r.status = STAT_FULL;
                for (step = 0; step < n; step++)
                begin
                    if (!shadow_used[idx])
                    begin
                        shadow_key[idx] = it.key;
                        shadow_row[idx] = it.row;
                        shadow_used[idx] = 1'b1;
                        r.status = STAT_DONE;
                        break;
                    end
                    idx = (idx + 1) & mask;
                end
            end
            OP_PROBE:
            begin
                inner = (cur_mode != MODE_SEMI) && (cur_mode != MODE_ANTI);
                found = 1'b0;
                trunc = 1'b0;
                k = 0;
                for (step = 0; step < n && shadow_used[idx]; step++)
                begin
                    if (shadow_key[idx] == it.key)
                    begin
                        found = 1'b1;
                        if (!inner)
                            break;
                        if (k < MAX_MATCHES)
                        begin
                            expected_q.push_back('{STAT_MATCH, shadow_row[idx], it.row,
                                                   1'b0, 1'b0, 1'b0});
                            k++;
                        end
                        else
                            trunc = 1'b1;
                    end
                    idx = (idx + 1) & mask;
                end
                r.status = STAT_END;
                r.probe_row = it.row;
                r.selected = (cur_mode == MODE_ANTI) ? !found : found;
                r.truncated = trunc;
            end
            default:
            begin
            end
        endcase
        expected_q.push_back(r);
    endfunction

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        join_item_t it;
        bit         slot_free;
        bit         offer;
        int         pending_exp;
        if (!rst_n)
        begin
            items.valid     <= 1'b0;
            items.operation <= OP_CLEAR;
            items.key       <= '0;
            items.row       <= '0;
        end
        else
        begin
            slot_free = 1'b1;
            pending_exp = expected_q.size();
            if (items.valid && items.ready)
            begin
                it.op = op_t'(items.operation);
                it.key = items.key;
                it.row = items.row;
                it.drain = 1'b0;
                predict_join(it);
                items_sent++;
                pending_exp = expected_q.size();
            end
            else if (items.valid)
                slot_free = 1'b0;
            if (slot_free)
            begin
                offer = pending_q.size() > 0;
                if (offer && !(items_sent >= 40 && items_sent < 110))
                    offer = $urandom_range(99) >= 21;
                if (offer && pending_q[0].drain && pending_exp != 0)
                    offer = 1'b0;
                if (offer)
                begin
                    it = pending_q.pop_front();
                    items.operation <= it.op;
                    items.key       <= it.key;
                    items.row       <= it.row;
                end
                items.valid <= offer;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        join_result_t e;
        if (!rst_n)
        begin
            results.ready <= 1'b0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("result with no expectation: status %0d", results.status);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (results.status !== e.status)
                    begin
                        $error("status: expected %0d actual %0d", e.status, results.status);
                        errors++;
                    end
                    if (results.build_row !== e.build_row)
                    begin
                        $error("build_row: expected %h actual %h", e.build_row,
                               results.build_row);
                        errors++;
                    end
                    if (results.probe_row !== e.probe_row)
                    begin
                        $error("probe_row: expected %h actual %h", e.probe_row,
                               results.probe_row);
                        errors++;
                    end
                    if (results.selected !== e.selected)
                    begin
                        $error("selected: expected %0d actual %0d", e.selected,
                               results.selected);
                        errors++;
                    end
                    if (results.truncated !== e.truncated)
                    begin
                        $error("truncated: expected %0d actual %0d", e.truncated,
                               results.truncated);
                        errors++;
                    end
                    if (results.last !== e.last)
                    begin
                        $error("last: expected %0d actual %0d", e.last, results.last);
                        errors++;
                    end
                end
            end
            // one long hold-off, otherwise random stalls with a clean stretch
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else if (results_seen >= 60 && results_seen < 130)
                results.ready <= 1'b1;
            else
                results.ready <= $urandom_range(99) >= 21;
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_table_bits = (idx == REG_TABLE_BITS) ? value[3:0] : cur_table_bits;
        cur_mode = (idx == REG_JOIN_MODE) ? mode_t'(value[1:0]) : cur_mode;
    endtask

    // wait until every queued item is transferred and all its results are back
    task automatic wait_idle();
        while (items_sent != items_added || expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic add_item(input op_t op, input logic [31:0] key, input logic [31:0] row,
                            input bit drain);
        pending_q.push_back('{op, key, row, drain});
        items_added++;
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) < 8)
            return key_pool[$urandom_range(7)];
        return $urandom();
    endfunction

    // random well-formed mix: builds, probes on pooled keys, some noise
    task automatic random_items(input int count);
        int pick;
        foreach (key_pool[i])
            key_pool[i] = $urandom();
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                add_item(OP_INSERT, pick_key(), $urandom(), 1'b0);
            else if (pick < 90)
                add_item(OP_PROBE, pick_key(), $urandom(), pick == 60);
            else if (pick < 94)
                add_item(OP_CLEAR, $urandom(), $urandom(), 1'b0);
            else
                add_item(OP_NONE, $urandom(), $urandom(), 1'b0);
        end
        wait_idle();
    endtask

    initial
    begin
        errors = 0;
        items_added = 0;
        items_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        cur_table_bits = 4'd12;
        cur_mode = MODE_INNER;
        foreach (shadow_used[i])
            shadow_used[i] = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every operation, full table, wrap of a full walk
        apb_write(REG_TABLE_BITS, 32'd4);
        add_item(OP_CLEAR, 32'h0, 32'h0, 1'b0);
        add_item(OP_INSERT, 32'h8000_0000, 32'h0, 1'b0);
        add_item(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
        add_item(OP_INSERT, 32'h0, 32'h1234_5678, 1'b0);
        add_item(OP_INSERT, 32'h7fff_ffff, 32'h5555_aaaa, 1'b0);
        add_item(OP_PROBE, 32'h8000_0000, 32'hffff_ffff, 1'b0);
        add_item(OP_PROBE, 32'h7fff_ffff, 32'h0, 1'b0);
        add_item(OP_PROBE, 32'hffff_ffff, 32'haaaa_5555, 1'b0);
        add_item(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        for (int i = 0; i < 14; i++)
            add_item(OP_INSERT, 32'h0000_0100 + i, i, 1'b0);
        add_item(OP_PROBE, 32'h0bad_beef, 32'h77, 1'b0);
        add_item(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        wait_idle();

        // random phases over table sizes and join modes
        random_items(30);
        apb_write(REG_JOIN_MODE, MODE_SEMI);
        random_items(30);
        apb_write(REG_JOIN_MODE, MODE_ANTI);
        apb_write(REG_TABLE_BITS, 32'd5);
        random_items(30);
        apb_write(REG_JOIN_MODE, MODE_ALT);
        apb_write(REG_TABLE_BITS, 32'd0);
        random_items(30);
        // table resized while filled
        apb_write(REG_TABLE_BITS, 32'd6);
        random_items(30);
        apb_write(REG_TABLE_BITS, 32'd15);
        apb_write(REG_JOIN_MODE, MODE_INNER);
        random_items(30);

        // more matches than can be reported
        apb_write(REG_TABLE_BITS, 32'd7);
        add_item(OP_CLEAR, 32'h0, 32'h0, 1'b0);
        for (int i = 0; i < 68; i++)
            add_item(OP_INSERT, 32'hdead_0001, $urandom(), 1'b0);
        add_item(OP_PROBE, 32'hdead_0001, $urandom(), 1'b0);
        wait_idle();
        apb_write(REG_JOIN_MODE, MODE_SEMI);
        add_item(OP_PROBE, 32'hdead_0001, $urandom(), 1'b0);
        wait_idle();
        apb_write(REG_TABLE_BITS, 32'd12);
        random_items(30);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
